// ===== hw/rtl/olpd_pkg.sv =====
`timescale 1ns / 1ps
package olpd_pkg;

   localparam int REQ_TYPE_W  = 3;
   localparam int VALUE_W     = 32;
   localparam int POSITION_W  = 4;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;

   localparam logic [REQ_TYPE_W-1:0] REQ_APPEND      = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_HEAD = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_TAIL = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_POS  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_DUMP        = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;

endpackage

// ===== hw/rtl/ordered_list_with_positional_delete.sv =====
`timescale 1ns / 1ps
// Single-result responses are registered as the request transfers. Dump: cells are read
// into a register, then registered out, one element per cycle while rsp_tready is high.
// Throughput: one request per cycle while rsp_tready is high; a dump takes no transfer
// until its last element is registered. A removal that moves cells holds req_tready
// low through S_SHIFT, which copies each later cell down one place, and S_DRAIN.
// Reset: entry count and handshake state cleared; cell memory is not cleared.
module ordered_list_with_positional_delete
   import olpd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] req_type, [34:3] item_value, [38:35] position, [39] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] status, [6:2] entry_count, [38:7] read_value, [39] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DUMP  = 2'd3;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] mem_rdata_ff;
   logic [AW-1:0]      mem_raddr;
   logic [AW-1:0]      mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic               mem_we;

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      idx_nx;
   logic               rdv_ff, rdv_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   count_type          rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [REQ_TYPE_W-1:0] req_type;
   logic [VALUE_W-1:0]    req_value;
   logic [POSITION_W-1:0] req_pos;
   logic                  out_free;
   logic                  req_fire;
   logic [XW-1:0]         cnt_x;
   logic [XW-1:0]         rem_pos_x;
   logic [XW-1:0]         rem_next_x;
   logic                  dump_last;

   assign req_type  = req_tdata[2:0];
   assign req_value = req_tdata[34:3];
   assign req_pos   = req_tdata[38:35];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign cnt_x      = XW'(count_ff);
   assign rem_pos_x  = (req_type == REQ_REMOVE_HEAD) ? '0 : XW'(req_pos);
   assign rem_next_x = rem_pos_x + XW'(1);
   assign idx_nx     = idx_ff + CW'(1);
   assign dump_last  = (idx_nx == count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rdv_in        = 1'b0;
      wr_addr_in    = idx_ff[AW-1:0] - AW'(1);
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      mem_raddr     = '0;
      mem_we        = rdv_ff;
      mem_waddr     = wr_addr_ff;
      mem_wdata     = mem_rdata_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               case (req_type)
                  REQ_APPEND: begin
                     if (cnt_x >= XW'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_value;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  REQ_REMOVE_HEAD, REQ_REMOVE_POS: begin
                     if (rem_pos_x >= cnt_x) begin
                        rsp_status_in = (req_type == REQ_REMOVE_HEAD) ? ST_EMPTY : ST_BADPOS;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (rem_next_x < cnt_x) begin
                           idx_in   = CW'(rem_next_x);
                           state_in = S_SHIFT;
                        end
                     end
                  end
                  REQ_REMOVE_TAIL: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  REQ_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                        state_in     = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         S_SHIFT: begin
            // read cell idx now, write it to idx-1 next cycle
            mem_raddr  = idx_ff[AW-1:0];
            rdv_in     = 1'b1;
            wr_addr_in = idx_ff[AW-1:0] - AW'(1);
            idx_in     = idx_nx;
            if (idx_ff == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         S_DUMP: begin
            mem_raddr = idx_ff[AW-1:0];
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_value_in  = mem_rdata_ff;
               rsp_last_in   = dump_last;
               idx_in        = idx_nx;
               mem_raddr     = idx_nx[AW-1:0];
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      wr_addr_ff    <= wr_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff, rsp_count_ff, rsp_status_ff};

endmodule

// ===== hw/rtl/olpd_checker.sv =====
`timescale 1ns / 1ps
module olpd_checker
   import olpd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transfer changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // mid-dump: no new request taken
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during dump");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_FULL) |-> rsp_tdata[6:2] == COUNT_W'(DEPTH))
      else $error("full status with wrong count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH > 31) || (32'(rsp_tdata[6:2]) <= 32'(DEPTH)))
      else $error("entry count beyond depth");

endmodule

bind ordered_list_with_positional_delete olpd_checker #(.DEPTH(DEPTH)) u_olpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import olpd_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int OPS_WANTED = 190;

   typedef struct {
      logic [REQ_TYPE_W-1:0]      kind;
      logic signed [VALUE_W-1:0]  value;
      logic [POSITION_W-1:0]      pos;
   } list_op_t;

   typedef struct {
      status_type                 status;
      count_type                  count;
      logic signed [VALUE_W-1:0]  value;
      logic                       is_last;
   } list_rsp_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [2:0] req_type, [34:3] item_value, [38:35] position, [39] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [1:0] status, [6:2] entry_count, [38:7] read_value, [39] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   list_op_t  list_ops_to_send[$];
   list_rsp_t list_rsp_q[$];
   logic signed [VALUE_W-1:0] mirror_cells[LIST_DEPTH];
   int mirror_len = 0;
   int ops_accepted = 0;
   int total_ops = 0;
   int mismatches = 0;
   int burst_left = 0;
   int gap_left = 0;
   int ready_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   ordered_list_with_positional_delete #(.DEPTH(LIST_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_op_t make_op(logic [REQ_TYPE_W-1:0] kind,
                                        logic signed [VALUE_W-1:0] value,
                                        logic [POSITION_W-1:0] pos);
      list_op_t op;
      op.kind  = kind;
      op.value = value;
      op.pos   = pos;
      return op;
   endfunction

   task automatic drop_cell(input int idx);
      int i;
      for (i = idx; i + 1 < mirror_len; i++) begin
         mirror_cells[i] = mirror_cells[i + 1];
      end
      mirror_len--;
   endtask

   task automatic run_list_op(input list_op_t op);
      list_rsp_t r;
      int i;
      r.status  = ST_OK;
      r.count   = '0;
      r.value   = '0;
      r.is_last = 1'b1;
      case (op.kind)
         REQ_APPEND: begin
            if (mirror_len >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               mirror_cells[mirror_len] = op.value;
               mirror_len++;
            end
         end
         REQ_REMOVE_HEAD: begin
            if (mirror_len == 0) r.status = ST_EMPTY;
            else drop_cell(0);
         end
         REQ_REMOVE_TAIL: begin
            if (mirror_len == 0) r.status = ST_EMPTY;
            else mirror_len--;
         end
         REQ_REMOVE_POS: begin
            if (int'(op.pos) >= mirror_len) r.status = ST_BADPOS;
            else drop_cell(int'(op.pos));
         end
         REQ_DUMP: begin
            if (mirror_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               for (i = 0; i < mirror_len; i++) begin
                  r.count   = count_type'(mirror_len);
                  r.value   = mirror_cells[i];
                  r.is_last = (i + 1 == mirror_len);
                  list_rsp_q.push_back(r);
               end
               return;
            end
         end
         default: ;
      endcase
      r.count = count_type'(mirror_len);
      list_rsp_q.push_back(r);
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(posedge clock) begin : drive
      list_op_t op;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0 || list_ops_to_send.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            op = list_ops_to_send.pop_front();
            req_tdata  <= {1'b0, op.pos, op.value, op.kind};
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // receiver: stall pattern in phases, plus one long hold-off
   always @(posedge clock) begin : accept
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && ops_accepted >= 120) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(5, 60);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : watch
      list_op_t op;
      list_rsp_t want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            op.kind  = req_tdata[2:0];
            op.value = req_tdata[34:3];
            op.pos   = req_tdata[38:35];
            run_list_op(op);
            ops_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (list_rsp_q.size() == 0) begin
               $error("result transfer with none expected: tdata %h last %b",
                      rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = list_rsp_q.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_tdata[1:0]);
                  mismatches++;
               end
               if (rsp_tdata[6:2] !== want.count) begin
                  $error("entry_count expected %0d got %0d", want.count, rsp_tdata[6:2]);
                  mismatches++;
               end
               if (rsp_tdata[38:7] !== want.value) begin
                  $error("read_value expected %0d got %0d", want.value,
                         $signed(rsp_tdata[38:7]));
                  mismatches++;
               end
               if (rsp_tlast !== want.is_last) begin
                  $error("last expected %0d got %0d", want.is_last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic signed [VALUE_W-1:0] extremes[4];
      int gen_len;
      int n;
      int pick;
      bit growing;
      logic signed [VALUE_W-1:0] v;
      logic [POSITION_W-1:0] p;
      extremes[0] = 32'sh8000_0000;
      extremes[1] = 32'sh7fff_ffff;
      extremes[2] = 32'sh0;
      extremes[3] = -32'sd1;

      // empty list corner cases, unused codes, extreme values, positional removes
      list_ops_to_send.push_back(make_op(REQ_DUMP, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_HEAD, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_TAIL, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_POS, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_POS, 32'sh0, 4'd15));
      list_ops_to_send.push_back(make_op(3'd5, 32'sh1234_5678, 4'd3));
      list_ops_to_send.push_back(make_op(3'd6, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(3'd7, -32'sd1, 4'd15));
      foreach (extremes[i]) list_ops_to_send.push_back(make_op(REQ_APPEND, extremes[i], 4'd15));
      list_ops_to_send.push_back(make_op(REQ_DUMP, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_POS, 32'sh0, 4'd4));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_POS, 32'sh0, 4'd1));
      list_ops_to_send.push_back(make_op(3'd7, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_POS, 32'sh0, 4'd2));
      list_ops_to_send.push_back(make_op(REQ_DUMP, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_HEAD, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_REMOVE_TAIL, 32'sh0, 4'd0));
      list_ops_to_send.push_back(make_op(REQ_DUMP, 32'sh0, 4'd0));

      // random part: alternate between filling and draining the list
      gen_len = 0;
      n = 0;
      growing = 1'b1;
      while (n < OPS_WANTED) begin
         if (growing && gen_len == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
         else if (!growing && gen_len == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
         else if ($urandom_range(0, 99) < 3) growing = !growing;
         pick = $urandom_range(0, 99);
         v = ($urandom_range(0, 7) == 0) ? extremes[$urandom_range(0, 3)] : $urandom;
         if (gen_len > 0 && $urandom_range(0, 4) != 0) begin
            p = POSITION_W'($urandom_range(0, gen_len - 1));
         end else begin
            p = POSITION_W'($urandom_range(0, 15));
         end
         if (pick < (growing ? 55 : 15)) begin
            list_ops_to_send.push_back(make_op(REQ_APPEND, v, p));
            if (gen_len < LIST_DEPTH) gen_len++;
            n++;
         end else if (pick < (growing ? 63 : 35)) begin
            list_ops_to_send.push_back(make_op(REQ_REMOVE_HEAD, v, p));
            if (gen_len > 0) gen_len--;
            n++;
         end else if (pick < (growing ? 71 : 55)) begin
            list_ops_to_send.push_back(make_op(REQ_REMOVE_TAIL, v, p));
            if (gen_len > 0) gen_len--;
            n++;
         end else if (pick < (growing ? 83 : 80)) begin
            list_ops_to_send.push_back(make_op(REQ_REMOVE_POS, v, p));
            if (int'(p) < gen_len) gen_len--;
            n++;
         end else if (pick < (growing ? 93 : 92)) begin
            list_ops_to_send.push_back(make_op(REQ_DUMP, v, p));
            n++;
         end else begin
            list_ops_to_send.push_back(make_op(3'($urandom_range(5, 7)), v, p));
         end
      end
      total_ops = list_ops_to_send.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (ops_accepted < total_ops || list_rsp_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatches == 0) begin
         $display("[ordered_list_with_positional_delete] OK");
      end else begin
         $display("[ordered_list_with_positional_delete] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("[ordered_list_with_positional_delete] ERROR");
      $finish;
   end

endmodule

// ===== ordered_list_with_positional_delete.f =====
hw/rtl/olpd_pkg.sv
hw/rtl/ordered_list_with_positional_delete.sv
hw/rtl/olpd_checker.sv
dv/tb.sv
